FILE: hw/rtl/ring_modulator_dry_wet_macros.svh
// Assertion macros for the ring modulator block.
`ifndef RING_MODULATOR_DRY_WET_MACROS_SVH
`define RING_MODULATOR_DRY_WET_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RMDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rmdw: same-cycle check failed");

`define RMDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rmdw: next-cycle check failed");

`else

`define RMDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define RMDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/rmdw_pkg.sv
// Shared types, constants and sine table function for the ring modulator.
package rmdw_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int PHASE_W     = 32;
    localparam int STEP_W      = 31;
    localparam int GAIN_W      = 16;
    localparam int CHAN_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int SINE_W      = 16;
    localparam int COEF_W      = 32;
    localparam int ACC_W       = SAMPLE_W + COEF_W;

    localparam int CHAN_LIMIT          = 2;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int MID_DEPTH           = 2;
    localparam int OUT_DEPTH           = 8;

    localparam logic [STEP_W-1:0] RST_PHASE_STEP = 31'd2684355;
    localparam logic [GAIN_W-1:0] RST_WET_GAIN   = 16'd16384;
    localparam logic [CHAN_W-1:0] RST_CHANNELS   = 2'd2;
    localparam logic [GAIN_W-1:0] WET_ONE        = 16'd32768;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_STEP = 2'd0,
        CFG_WET_GAIN   = 2'd1,
        CFG_CHANNELS   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_ch0;
        logic signed [SAMPLE_W-1:0] sample_ch1;
        logic                       last_in_block;
        logic [PHASE_W-1:0]         phase;
    } t_frame;

    typedef struct packed {
        logic [GAIN_W-1:0] wet;
        logic              en_ch0;
        logic              en_ch1;
    } t_mix_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] result_ch0;
        logic signed [SAMPLE_W-1:0] result_ch1;
        logic                       block_done;
    } t_result;

    // Q1.15 quarter-wave sine, Taylor series in Q2.30 (elaboration only).
    function automatic logic signed [SINE_W-1:0] quarter_sine(
        input longint unsigned r,
        input int unsigned     bits
    );
        longint unsigned t;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned s;
        t    = (r * HALF_PI_Q30) >> (bits - 2);
        t2   = (t * t) >> 30;
        term = Q30_ONE;
        term = Q30_ONE - ((t2 * term) >> 30) / 110;
        term = Q30_ONE - ((t2 * term) >> 30) / 72;
        term = Q30_ONE - ((t2 * term) >> 30) / 42;
        term = Q30_ONE - ((t2 * term) >> 30) / 20;
        term = Q30_ONE - ((t2 * term) >> 30) / 6;
        s    = (t * term) >> 30;
        s    = (s + (64'd1 << 14)) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return SINE_W'(s);
    endfunction

    function automatic logic signed [SINE_W-1:0] sine_entry(
        input int unsigned idx,
        input int unsigned bits
    );
        longint unsigned quarter;
        longint unsigned q;
        longint unsigned r;
        logic signed [SINE_W-1:0] v;
        quarter = 64'd1 << (bits - 2);
        q       = 64'(idx) >> (bits - 2);
        r       = 64'(idx) & (quarter - 1);
        case (q)
            64'd0:   v = quarter_sine(r, bits);
            64'd1:   v = quarter_sine(quarter - r, bits);
            64'd2:   v = -quarter_sine(r, bits);
            default: v = -quarter_sine(quarter - r, bits);
        endcase
        return v;
    endfunction

    // Round half up from Q3.53 to Q1.23 and saturate.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0]   rnd;
        logic signed [ACC_W-30:0] q;
        logic signed [SAMPLE_W-1:0] y;
        rnd = {acc[ACC_W-1], acc} + (ACC_W+1)'(64'd1 << 29);
        q   = rnd[ACC_W:30];
        if (q > (ACC_W-29)'(24'sh7FFFFF)) begin
            y = 24'sh7FFFFF;
        end else if (q < -(ACC_W-29)'(64'sd8388608)) begin
            y = 24'sh800000;
        end else begin
            y = q[SAMPLE_W-1:0];
        end
        return y;
    endfunction

endpackage

FILE: hw/rtl/rmdw_fifo.sv
// Small register queue with full, empty and fill count.
module rmdw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [WIDTH-1:0]             o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

FILE: hw/rtl/rmdw_front.sv
// Front end: config registers, phase accumulator, frame intake.
`include "ring_modulator_dry_wet_macros.svh"

module rmdw_front import rmdw_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic signed [SAMPLE_W-1:0] i_sample_ch0,
    input  logic signed [SAMPLE_W-1:0] i_sample_ch1,
    input  logic                       i_last_in_block,
    output logic                       o_mid_push,
    output t_frame                     o_mid_data,
    input  logic                       i_mid_full,
    output t_mix_cfg                   o_mix_cfg
);
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [STEP_W-1:0]  r_phase_step;
    logic [GAIN_W-1:0]  r_wet_gain;
    logic [CHAN_W-1:0]  r_channels;
    logic               cfg_we;
    logic               chan_we;
    logic               accept;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign chan_we     = cfg_we && (i_cfg_index == CFG_CHANNELS);
    assign o_full      = i_mid_full;
    assign accept      = i_push && !i_mid_full;
    assign n_phase     = r_phase + {1'b0, r_phase_step};

    assign o_mid_push                = accept;
    assign o_mid_data.sample_ch0     = i_sample_ch0;
    assign o_mid_data.sample_ch1     = i_sample_ch1;
    assign o_mid_data.last_in_block  = i_last_in_block;
    assign o_mid_data.phase          = r_phase;

    assign o_mix_cfg.wet    = (r_wet_gain > WET_ONE) ? WET_ONE : r_wet_gain;
    assign o_mix_cfg.en_ch0 = (r_channels >= 2'd1) && (CHAN_LIMIT >= 1);
    assign o_mix_cfg.en_ch1 = (r_channels >= 2'd2) && (CHAN_LIMIT >= 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_phase_step <= RST_PHASE_STEP;
            r_wet_gain   <= RST_WET_GAIN;
            r_channels   <= RST_CHANNELS;
        end else begin
            if (cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PHASE_STEP: r_phase_step <= i_cfg_data[STEP_W-1:0];
                    CFG_WET_GAIN:   r_wet_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_CHANNELS:   r_channels   <= i_cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
            end
        end
    end

    `RMDW_ASSERT_NEXT(a_phase_adv, i_clk, i_rst_n, accept, r_phase == $past(n_phase))
    `RMDW_ASSERT_NEXT(a_phase_hold, i_clk, i_rst_n, !accept, $stable(r_phase))
    `RMDW_ASSERT_NEXT(a_chan, i_clk, i_rst_n, chan_we, r_channels == $past(i_cfg_data[CHAN_W-1:0]))
endmodule

FILE: hw/rtl/rmdw_back.sv
// Back end: sine lookup, mix multiply pipeline, rounding, result queue.
`include "ring_modulator_dry_wet_macros.svh"

module rmdw_back import rmdw_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_mid_empty,
    input  t_frame   i_mid_data,
    output logic     o_mid_pop,
    input  t_mix_cfg i_mix_cfg,
    output logic     o_empty,
    input  logic     i_pop,
    output t_result  o_result
);
    localparam int TBL_SIZE = 1 << SINE_TABLE_BITS;
    localparam int CNT_W    = $clog2(OUT_DEPTH + 1);

    logic signed [SINE_W-1:0] sine_rom [TBL_SIZE];

    for (genvar gi = 0; gi < TBL_SIZE; gi++) begin : g_rom
        assign sine_rom[gi] = sine_entry(gi, SINE_TABLE_BITS);
    end

    logic                       r_v1, r_v2, r_v3;
    logic signed [SAMPLE_W-1:0] r_x0_1, r_x1_1, r_x0_2, r_x1_2, r_x0_3, r_x1_3;
    logic                       r_last_1, r_last_2, r_last_3;
    logic signed [SINE_W-1:0]   r_sine_1;
    logic signed [COEF_W-1:0]   r_coef_2;
    logic signed [ACC_W-1:0]    r_acc0_3, r_acc1_3;

    logic [GAIN_W:0]            dry;
    logic signed [GAIN_W+SINE_W:0] wet_term;
    logic signed [GAIN_W+SINE_W:0] dry_term;
    logic signed [GAIN_W+SINE_W:0] coef_sum;
    logic signed [ACC_W-1:0]    prod0, prod1;

    logic [1:0]                 inflight;
    logic [CNT_W:0]             occ;
    logic                       launch;
    logic                       out_full;
    logic                       out_pop;
    logic [CNT_W-1:0]           out_count;
    t_result                    res;

    assign inflight  = 2'({1'b0, r_v1} + {1'b0, r_v2}) + {1'b0, r_v3};
    assign occ       = {1'b0, out_count} + (CNT_W+1)'(inflight);
    assign launch    = !i_mid_empty && (occ < (CNT_W+1)'(OUT_DEPTH));
    assign o_mid_pop = launch;
    assign out_pop   = i_pop && !o_empty;

    assign dry      = (GAIN_W+1)'(WET_ONE) - {1'b0, i_mix_cfg.wet};
    assign wet_term = $signed({1'b0, i_mix_cfg.wet}) * r_sine_1;
    assign dry_term = $signed({1'b0, dry, 15'b0});
    assign coef_sum = dry_term + wet_term;
    assign prod0    = r_x0_2 * r_coef_2;
    assign prod1    = r_x1_2 * r_coef_2;

    assign res.result_ch0 = i_mix_cfg.en_ch0 ? round_sat(r_acc0_3) : r_x0_3;
    assign res.result_ch1 = i_mix_cfg.en_ch1 ? round_sat(r_acc1_3) : r_x1_3;
    assign res.block_done = r_last_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= launch;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0_1   <= i_mid_data.sample_ch0;
        r_x1_1   <= i_mid_data.sample_ch1;
        r_last_1 <= i_mid_data.last_in_block;
        r_sine_1 <= sine_rom[i_mid_data.phase[PHASE_W-1 -: SINE_TABLE_BITS]];

        r_x0_2   <= r_x0_1;
        r_x1_2   <= r_x1_1;
        r_last_2 <= r_last_1;
        r_coef_2 <= coef_sum[COEF_W-1:0];

        r_x0_3   <= r_x0_2;
        r_x1_3   <= r_x1_2;
        r_last_3 <= r_last_2;
        r_acc0_3 <= prod0;
        r_acc1_3 <= prod1;
    end

    rmdw_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v3),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_result),
        .o_count (out_count)
    );

    `RMDW_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_v3, !out_full)
    `RMDW_ASSERT_IMP(a_credit, i_clk, i_rst_n, 1'b1, occ <= (CNT_W+1)'(OUT_DEPTH))
    `RMDW_ASSERT_NEXT(a_fill, i_clk, i_rst_n, r_v3 && !out_pop, out_count == $past(out_count) + 1'b1)
endmodule

FILE: hw/rtl/ring_modulator_dry_wet.sv
// Top level of the ring modulator with sine carrier and dry/wet mix.
//
//  channel  direction  handshake              payload
//  config   in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//  frame    in         push/full              i_sample_ch0, i_sample_ch1, i_last_in_block
//  result   out        pop/empty              o_result_ch0, o_result_ch1, o_block_done
//
// One word per cycle sustained while pop drains the results; full holds the input off otherwise.
// A frame passes the middle queue, the sine ROM read, the coefficient multiply, the sample multiply
// and the result queue write; an 8-entry result queue gives the multiplier pipeline its credit.
// Reset clears the phase and loads the default step, gain and channel count; no warm-up.
// With pop low the result queue fills, the pipeline holds off and full rises on the input.
module ring_modulator_dry_wet import rmdw_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic signed [SAMPLE_W-1:0] i_sample_ch0,
    input  logic signed [SAMPLE_W-1:0] i_sample_ch1,
    input  logic                       i_last_in_block,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] o_result_ch0,
    output logic signed [SAMPLE_W-1:0] o_result_ch1,
    output logic                       o_block_done
);
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

    logic                 mid_push;
    t_frame               mid_wdata;
    t_frame               mid_rdata;
    logic                 mid_full;
    logic                 mid_empty;
    logic                 mid_pop;
    logic [MID_CNT_W-1:0] mid_count;
    t_mix_cfg             mix_cfg;
    t_result              result;

    rmdw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_push          (push),
        .o_full          (full),
        .i_sample_ch0    (i_sample_ch0),
        .i_sample_ch1    (i_sample_ch1),
        .i_last_in_block (i_last_in_block),
        .o_mid_push      (mid_push),
        .o_mid_data      (mid_wdata),
        .i_mid_full      (mid_full),
        .o_mix_cfg       (mix_cfg)
    );

    rmdw_fifo #(
        .WIDTH ($bits(t_frame)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_wdata),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_rdata),
        .o_count (mid_count)
    );

    rmdw_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty || (mid_count == '0)),
        .i_mid_data  (mid_rdata),
        .o_mid_pop   (mid_pop),
        .i_mix_cfg   (mix_cfg),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result)
    );

    assign o_result_ch0 = result.result_ch0;
    assign o_result_ch1 = result.result_ch1;
    assign o_block_done = result.block_done;
endmodule

FILE: dv/ring_modulator_dry_wet_check.sv
// Channel monitor for the ring modulator: predicts each mixed frame and compares results.
module ring_modulator_dry_wet_check import rmdw_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_push,
    input  logic                       i_full,
    input  logic signed [SAMPLE_W-1:0] i_sample_ch0,
    input  logic signed [SAMPLE_W-1:0] i_sample_ch1,
    input  logic                       i_last_in_block,
    input  logic                       i_pop,
    input  logic                       i_empty,
    input  logic signed [SAMPLE_W-1:0] i_result_ch0,
    input  logic signed [SAMPLE_W-1:0] i_result_ch1,
    input  logic                       i_block_done,
    output int                         o_mismatches,
    output int                         o_pending
);
    localparam int LUT_BITS     = SINE_TABLE_BITS_DEF;
    localparam int LUT_SIZE     = 1 << LUT_BITS;
    localparam int QUARTER_SIZE = LUT_SIZE / 4;
    localparam int MAX_REPORTS  = 10;

    logic signed [SINE_W-1:0] sine_lut [LUT_SIZE];
    logic [STEP_W-1:0]        step_q;
    logic [GAIN_W-1:0]        wet_q;
    logic [CHAN_W-1:0]        chans_q;
    logic [PHASE_W-1:0]       phase_q;
    t_result                  mixed_q [$];
    int                       mismatch_cnt;

    // Q1.15 sine over a quarter turn, Taylor series in Q2.30.
    function automatic logic signed [SINE_W-1:0] quarter_wave(input int unsigned r);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned s;
        t    = (64'(r) * HALF_PI_Q30) / 64'(QUARTER_SIZE);
        t2   = (t * t) >> 30;
        term = Q30_ONE;
        for (int k = 10; k >= 2; k -= 2) begin
            term = Q30_ONE - ((t2 * term) >> 30) / 64'(k * (k + 1));
        end
        s = (t * term) >> 30;
        s = (s + (64'd1 << 14)) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[SINE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] mix_channel(
        input logic signed [SAMPLE_W-1:0] x,
        input logic signed [SINE_W-1:0]   sine,
        input logic [GAIN_W-1:0]          wet
    );
        longint xs;
        longint sn;
        longint w;
        longint coef;
        longint q;
        xs   = x;
        sn   = sine;
        w    = wet;
        coef = (32768 - w) * 32768 + w * sn;
        q    = (xs * coef + (longint'(1) <<< 29)) >>> 30;
        if (q > 8388607) begin
            q = 8388607;
        end else if (q < -8388608) begin
            q = -8388608;
        end
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic t_result predict_frame(
        input logic signed [SAMPLE_W-1:0] s0,
        input logic signed [SAMPLE_W-1:0] s1,
        input logic                       last
    );
        t_result                  r;
        logic [GAIN_W-1:0]        wet;
        logic signed [SINE_W-1:0] sine;
        int                       active;
        wet    = (wet_q > WET_ONE) ? WET_ONE : wet_q;
        active = (chans_q > CHAN_LIMIT) ? CHAN_LIMIT : int'(chans_q);
        sine   = sine_lut[phase_q[PHASE_W-1 -: LUT_BITS]];
        r.result_ch0 = (active >= 1) ? mix_channel(s0, sine, wet) : s0;
        r.result_ch1 = (active >= 2) ? mix_channel(s1, sine, wet) : s1;
        r.block_done = last;
        return r;
    endfunction

    initial begin
        for (int i = 0; i < LUT_SIZE; i++) begin
            case (i / QUARTER_SIZE)
                0:       sine_lut[i] = quarter_wave(i % QUARTER_SIZE);
                1:       sine_lut[i] = quarter_wave(QUARTER_SIZE - i % QUARTER_SIZE);
                2:       sine_lut[i] = -quarter_wave(i % QUARTER_SIZE);
                default: sine_lut[i] = -quarter_wave(QUARTER_SIZE - i % QUARTER_SIZE);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            step_q       = RST_PHASE_STEP;
            wet_q        = RST_WET_GAIN;
            chans_q      = RST_CHANNELS;
            phase_q      = '0;
            mismatch_cnt = 0;
            mixed_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PHASE_STEP: step_q  = i_cfg_data[STEP_W-1:0];
                    CFG_WET_GAIN:   wet_q   = i_cfg_data[GAIN_W-1:0];
                    CFG_CHANNELS:   chans_q = i_cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                got.result_ch0 = i_result_ch0;
                got.result_ch1 = i_result_ch1;
                got.block_done = i_block_done;
                if (mixed_q.size() == 0) begin
                    if (mismatch_cnt < MAX_REPORTS) begin
                        $display("unexpected word: ch0=%0d ch1=%0d done=%0b",
                                 got.result_ch0, got.result_ch1, got.block_done);
                    end
                    mismatch_cnt++;
                end else begin
                    want = mixed_q.pop_front();
                    if (got.result_ch0 !== want.result_ch0 ||
                        got.result_ch1 !== want.result_ch1 ||
                        got.block_done !== want.block_done) begin
                        if (mismatch_cnt < MAX_REPORTS) begin
                            $display("exp ch0=%0d ch1=%0d done=%0b got ch0=%0d ch1=%0d done=%0b",
                                     want.result_ch0, want.result_ch1, want.block_done,
                                     got.result_ch0, got.result_ch1, got.block_done);
                        end
                        mismatch_cnt++;
                    end
                end
            end
            if (i_push && !i_full) begin
                mixed_q.push_back(predict_frame(i_sample_ch0, i_sample_ch1, i_last_in_block));
                phase_q = phase_q + PHASE_W'(step_q);
            end
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= mixed_q.size();
    end

endmodule

FILE: dv/ring_modulator_dry_wet_test.sv
// Stimulus and verdict for the ring modulator with dry/wet mix.
module ring_modulator_dry_wet_test import rmdw_pkg::*;;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_FRAMES = 1780;
    localparam int SQUEEZE_LEN   = 150;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       push;
    logic                       full;
    logic signed [SAMPLE_W-1:0] sample_ch0;
    logic signed [SAMPLE_W-1:0] sample_ch1;
    logic                       last_in_block;
    logic                       empty;
    logic                       pop;
    logic signed [SAMPLE_W-1:0] result_ch0;
    logic signed [SAMPLE_W-1:0] result_ch1;
    logic                       block_done;

    int mismatches;
    int pending;
    int burst_left;
    bit stress_on;
    bit squeeze_done;

    ring_modulator_dry_wet u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .push            (push),
        .full            (full),
        .i_sample_ch0    (sample_ch0),
        .i_sample_ch1    (sample_ch1),
        .i_last_in_block (last_in_block),
        .empty           (empty),
        .pop             (pop),
        .o_result_ch0    (result_ch0),
        .o_result_ch1    (result_ch1),
        .o_block_done    (block_done)
    );

    ring_modulator_dry_wet_check u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_push          (push),
        .i_full          (full),
        .i_sample_ch0    (sample_ch0),
        .i_sample_ch1    (sample_ch1),
        .i_last_in_block (last_in_block),
        .i_pop           (pop),
        .i_empty         (empty),
        .i_result_ch0    (result_ch0),
        .i_result_ch1    (result_ch1),
        .i_block_done    (block_done),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offers one frame, at a burst boundary often after a random gap.
    task automatic send_frame(
        input logic signed [SAMPLE_W-1:0] s0,
        input logic signed [SAMPLE_W-1:0] s1,
        input logic                       last
    );
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 10);
            end
        end
        burst_left--;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        sample_ch0    <= s0;
        sample_ch1    <= s1;
        last_in_block <= last;
        do @(posedge clk); while (full);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(
        input logic [CFG_DATA_W-1:0] step,
        input logic [CFG_DATA_W-1:0] wet,
        input logic [CFG_DATA_W-1:0] chans
    );
        wait_idle();
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_WET_GAIN, wet);
        write_reg(CFG_CHANNELS, chans);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] any_sample();
        case ($urandom_range(0, 7))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return SAMPLE_W'($urandom_range(0, 511)) - 24'd256;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Result side: random pop patterns, plus one long hold-off under load.
    initial begin
        int mode;
        int span;
        pop <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(32, 200);
            for (int tick = 0; tick < span; tick++) begin
                if (stress_on && !squeeze_done) begin
                    squeeze_done = 1'b1;
                    pop <= 1'b0;
                    repeat (SQUEEZE_LEN) @(posedge clk);
                end
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= ((tick % 8) < 3);
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int left;
        int n;
        logic [CFG_DATA_W-1:0] step;
        logic [CFG_DATA_W-1:0] wet;
        logic [CFG_DATA_W-1:0] chans;

        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_PHASE_STEP;
        cfg_data      <= '0;
        push          <= 1'b0;
        sample_ch0    <= '0;
        sample_ch1    <= '0;
        last_in_block <= 1'b0;
        burst_left    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full-scale and near-zero samples
        send_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
        send_frame(24'sh800000, 24'sh7FFFFF, 1'b1);
        send_frame(24'sh000000, 24'sh000000, 1'b0);
        send_frame(24'shFFFFFF, 24'sh000001, 1'b1);

        // quarter-turn steps, fully wet: carrier near its peaks and zero crossings
        configure(32'h4000_0000, 32'd32768, 32'd2);
        send_frame(24'sh800000, 24'sh800000, 1'b0);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        send_frame(24'sh800000, 24'sh7FFFFF, 1'b0);
        send_frame(24'sh7FFFFF, 24'sh800000, 1'b1);

        // fully dry
        configure(32'h4000_0000, 32'd0, 32'd2);
        send_frame(24'sh800000, 24'sh123456, 1'b0);
        send_frame(24'sh7FFFFF, 24'shABCDEF, 1'b1);

        // gain above one, step with top bit set
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
        send_frame(24'sh800000, 24'sh7FFFFF, 1'b0);
        send_frame(24'sh654321, 24'sh800000, 1'b1);

        // one channel only
        configure(32'h1234_5678, 32'd20000, 32'd1);
        send_frame(24'sh800000, 24'sh7FFFFF, 1'b0);
        send_frame(24'sh400000, 24'shC00000, 1'b1);

        // no channel processed, phase still moves
        configure(32'h2000_0000, 32'd32768, 32'd0);
        send_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
        send_frame(24'sh0F0F0F, 24'shF0F0F0, 1'b1);

        // count above the channel limit
        configure(32'h2000_0000, 32'd32768, 32'd3);
        send_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
        send_frame(24'sh555555, 24'shAAAAAA, 1'b0);

        // zero step: phase holds
        configure(32'd0, 32'd24576, 32'd2);
        send_frame(24'sh7FFFFF, 24'sh800000, 1'b1);
        send_frame(24'sh333333, 24'shCCCCCC, 1'b0);

        left = RANDOM_FRAMES;
        while (left > 0) begin
            case ($urandom_range(0, 5))
                0:       step = '0;
                1:       step = 32'hFFFF_FFFF;
                2:       step = $urandom_range(0, 65535);
                default: step = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       wet = {16'($urandom), 16'd0};
                1:       wet = {16'($urandom), 16'd32768};
                2:       wet = $urandom;
                default: wet = {16'($urandom), 16'($urandom_range(0, 32768))};
            endcase
            case ($urandom_range(0, 7))
                0:       chans = {30'($urandom), 2'd0};
                1:       chans = {30'($urandom), 2'd3};
                2, 3, 4: chans = {30'($urandom), 2'd1};
                default: chans = {30'($urandom), 2'd2};
            endcase
            configure(step, wet, chans);
            stress_on = 1'b1;
            n = $urandom_range(60, 250);
            if (n > left) begin
                n = left;
            end
            repeat (n) begin
                send_frame(any_sample(), any_sample(), ($urandom_range(0, 7) == 0));
            end
            left -= n;
        end

        wait_idle();
        repeat (12) @(posedge clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/rmdw_pkg.sv
hw/rtl/rmdw_fifo.sv
hw/rtl/rmdw_front.sv
hw/rtl/rmdw_back.sv
hw/rtl/ring_modulator_dry_wet.sv
dv/ring_modulator_dry_wet_check.sv
dv/ring_modulator_dry_wet_test.sv
